// ===== src/dbc_pkg.sv =====
package dbc_pkg;

    localparam int ID_BITS_DEF   = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int MAC_W   = 48;
    localparam int MODE_W  = 2;
    localparam int LAA_BIT = 41;   // locally administered bit of the first octet

    localparam logic [MODE_W-1:0] MODE_ADD        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WEIGH_CLR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WEIGH_PEEK = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESET      = 2'd3;

    localparam int MAX_WORD_W = 64;
    localparam int POP_W      = 7;

    // control from the sequencer to the count pipeline
    typedef struct packed {
        logic start;    // zero both accumulators
        logic valid;    // RAM read data is a map word to count
        logic is_ble;   // word belongs to the BLE map
    } t_acc_ctl;

    function automatic logic [POP_W-1:0] popcount(input logic [MAX_WORD_W-1:0] v);
        logic [POP_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < MAX_WORD_W; i++) begin
            sum = sum + {{(POP_W-1){1'b0}}, v[i]};
        end
        return sum;
    endfunction

endpackage

// ===== src/distinct_id_bitmap_counter.sv =====
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: mac_address; tuser: mode, radio
// m_axis    out  m_axis_tvalid/tready        tdata: is_new, wifi_count, ble_count
//
// An add reads the map word, then sets the bit, writes it back and loads the result
// once m_axis is free; an add of a universal address only loads the result. A weigh or
// reset-all accepts, reads each word of both maps once, drains the bit counter (two stages
// behind the reads) and loads the result. After reset the same pass clears the RAM with
// s_axis_tready low. A new transaction is taken while the last result waits on m_axis;
// a stalled result holds the block at its final step.
module distinct_id_bitmap_counter #(
    parameter int ID_BITS   = dbc_pkg::ID_BITS_DEF,
    parameter int WORD_BITS = dbc_pkg::WORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dbc_pkg::MAC_W-1:0]      s_axis_tdata,  // [47:0] mac_address
    input  logic [dbc_pkg::MODE_W:0]       s_axis_tuser,  // [1:0] mode, [2] radio
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [0] is_new, then wifi_count, then ble_count (ID_BITS+1 bits each), zero fill
    output logic [((2*ID_BITS+3+7)/8)*8-1:0] m_axis_tdata
);

    localparam int WORD_LOG   = $clog2(WORD_BITS);
    localparam int WORD_W     = 1 << WORD_LOG;      // map word, rounded to a power of two
    localparam int ADDR_W     = ID_BITS - WORD_LOG + 1;  // radio bit on top of word index
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int COUNT_W    = ID_BITS + 1;
    localparam int OUT_DATA_W = ((2*ID_BITS + 3 + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADD   = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // control state
    logic [2:0]          r_state, n_state;
    logic [ADDR_W-1:0]   r_addr, n_addr;       // sweep read pointer
    logic                r_clear, n_clear;     // sweep zeroes the words it reads
    logic                r_count, n_count;     // sweep publishes new totals
    logic                r_reply, n_reply;     // sweep ends with a result
    logic                r_rd_vld, n_rd_vld;   // RAM data holds a sweep word
    logic [COUNT_W-1:0]  r_wifi_total, n_wifi_total;
    logic [COUNT_W-1:0]  r_ble_total, n_ble_total;
    logic                r_out_valid, n_out_valid;
    // payload
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    logic [ADDR_W-1:0]   r_add_addr, n_add_addr;
    logic [WORD_LOG-1:0] r_bit, n_bit;
    logic                r_out_new, n_out_new;
    logic [COUNT_W-1:0]  r_out_wifi, n_out_wifi;
    logic [COUNT_W-1:0]  r_out_ble, n_out_ble;

    logic [dbc_pkg::MODE_W-1:0] w_mode;
    logic                w_radio;
    logic [15:0]         w_id16;
    logic [ID_BITS-1:0]  w_id;
    logic [ADDR_W-1:0]   w_add_addr;
    logic [WORD_W-1:0]   w_mask;
    logic                w_out_free;
    logic                w_rd_en;
    logic [ADDR_W-1:0]   w_rd_addr;
    logic [WORD_W-1:0]   w_rd_data;
    logic                w_wr_en;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [WORD_W-1:0]   w_wr_data;
    dbc_pkg::t_acc_ctl   w_ctl;
    logic                w_acc_busy;
    logic [COUNT_W-1:0]  w_wifi_acc;
    logic [COUNT_W-1:0]  w_ble_acc;

    assign w_mode  = s_axis_tuser[dbc_pkg::MODE_W-1:0];
    assign w_radio = s_axis_tuser[dbc_pkg::MODE_W];

    // id: last octet high, the one before it low
    assign w_id16     = {s_axis_tdata[7:0], s_axis_tdata[15:8]};
    assign w_id       = w_id16[ID_BITS-1:0];
    assign w_add_addr = {w_radio, w_id[ID_BITS-1:WORD_LOG]};
    assign w_mask     = {{(WORD_W-1){1'b0}}, 1'b1} << r_bit;
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_clear      = r_clear;
        n_count      = r_count;
        n_reply      = r_reply;
        n_rd_vld     = 1'b0;
        n_wifi_total = r_wifi_total;
        n_ble_total  = r_ble_total;
        n_rd_addr    = r_rd_addr;
        n_add_addr   = r_add_addr;
        n_bit        = r_bit;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_new    = r_out_new;
        n_out_wifi   = r_out_wifi;
        n_out_ble    = r_out_ble;

        w_rd_en      = 1'b0;
        w_rd_addr    = r_addr;
        w_ctl.start  = 1'b0;
        w_ctl.valid  = r_rd_vld && r_count;
        w_ctl.is_ble = r_rd_addr[ADDR_W-1];

        // zero each sweep word in the cycle after its read
        w_wr_en   = r_rd_vld && r_clear;
        w_wr_addr = r_rd_addr;
        w_wr_data = '0;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (w_mode)
                        dbc_pkg::MODE_ADD: begin
                            if (s_axis_tdata[dbc_pkg::LAA_BIT]) begin
                                w_rd_en    = 1'b1;
                                w_rd_addr  = w_add_addr;
                                n_add_addr = w_add_addr;
                                n_bit      = w_id[WORD_LOG-1:0];
                                n_state    = ST_ADD;
                            end else begin
                                n_state = ST_OUT;  // universal address: ignore
                            end
                        end
                        dbc_pkg::MODE_WEIGH_CLR, dbc_pkg::MODE_WEIGH_PEEK: begin
                            n_clear     = (w_mode == dbc_pkg::MODE_WEIGH_CLR);
                            n_count     = 1'b1;
                            n_reply     = 1'b1;
                            n_addr      = '0;
                            w_ctl.start = 1'b1;
                            n_state     = ST_SWEEP;
                        end
                        default: begin
                            n_clear      = 1'b1;
                            n_count      = 1'b0;
                            n_reply      = 1'b1;
                            n_addr       = '0;
                            n_wifi_total = '0;
                            n_ble_total  = '0;
                            n_state      = ST_SWEEP;
                        end
                    endcase
                end
            end
            ST_ADD: begin
                // hold the read word until the result slot frees up
                if (w_out_free) begin
                    w_wr_en     = 1'b1;
                    w_wr_addr   = r_add_addr;
                    w_wr_data   = w_rd_data | w_mask;
                    n_out_valid = 1'b1;
                    n_out_new   = ~|(w_rd_data & w_mask);
                    n_out_wifi  = r_wifi_total;
                    n_out_ble   = r_ble_total;
                    n_state     = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_addr;
                n_rd_vld  = 1'b1;
                n_rd_addr = r_addr;
                n_addr    = r_addr + 1'b1;
                if (r_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last word to clear and the count pipeline to empty
                if (!r_rd_vld && !w_acc_busy) begin
                    if (r_count) begin
                        n_wifi_total = w_wifi_acc;
                        n_ble_total  = w_ble_acc;
                    end
                    n_state = r_reply ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_new   = 1'b0;
                    n_out_wifi  = r_wifi_total;
                    n_out_ble   = r_ble_total;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_add_addr <= n_add_addr;
        r_bit      <= n_bit;
        r_out_new  <= n_out_new;
        r_out_wifi <= n_out_wifi;
        r_out_ble  <= n_out_ble;
        if (!i_rst_n) begin
            // start in a clearing pass over both maps
            r_state      <= ST_SWEEP;
            r_addr       <= '0;
            r_clear      <= 1'b1;
            r_count      <= 1'b0;
            r_reply      <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_wifi_total <= '0;
            r_ble_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_clear      <= n_clear;
            r_count      <= n_count;
            r_reply      <= n_reply;
            r_rd_vld     <= n_rd_vld;
            r_wifi_total <= n_wifi_total;
            r_ble_total  <= n_ble_total;
            r_out_valid  <= n_out_valid;
        end
    end

    // both seen-maps in one RAM, radio selects the upper half
    dbc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    dbc_popacc #(
        .WORD_W  (WORD_W),
        .COUNT_W (COUNT_W)
    ) u_popacc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_word     (w_rd_data),
        .o_busy     (w_acc_busy),
        .o_wifi_acc (w_wifi_acc),
        .o_ble_acc  (w_ble_acc)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_ble, r_out_wifi, r_out_new});

endmodule

// ===== src/dbc_ram.sv =====
module dbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/dbc_popacc.sv =====
module dbc_popacc #(
    parameter int WORD_W  = 32,
    parameter int COUNT_W = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dbc_pkg::t_acc_ctl  i_ctl,
    input  logic [WORD_W-1:0]  i_word,
    output logic               o_busy,
    output logic [COUNT_W-1:0] o_wifi_acc,
    output logic [COUNT_W-1:0] o_ble_acc
);

    localparam int PC_W = $clog2(WORD_W) + 1;

    logic                     r_pc_vld;
    logic                     r_pc_ble;
    logic [PC_W-1:0]          r_pc;
    logic [COUNT_W-1:0]       r_wifi_acc;
    logic [COUNT_W-1:0]       r_ble_acc;
    logic [dbc_pkg::POP_W-1:0] w_pop;
    logic [COUNT_W-1:0]       w_pc_ext;

    assign w_pop    = dbc_pkg::popcount(dbc_pkg::MAX_WORD_W'(i_word));
    assign w_pc_ext = {{(COUNT_W-PC_W){1'b0}}, r_pc};

    // stage 1: count the word; stage 2: add into the map's total
    always_ff @(posedge i_clk) begin
        r_pc     <= w_pop[PC_W-1:0];
        r_pc_ble <= i_ctl.is_ble;
        if (!i_rst_n) begin
            r_pc_vld   <= 1'b0;
            r_wifi_acc <= '0;
            r_ble_acc  <= '0;
        end else begin
            r_pc_vld <= i_ctl.valid;
            if (i_ctl.start) begin
                r_wifi_acc <= '0;
                r_ble_acc  <= '0;
            end else if (r_pc_vld) begin
                if (r_pc_ble) begin
                    r_ble_acc <= r_ble_acc + w_pc_ext;
                end else begin
                    r_wifi_acc <= r_wifi_acc + w_pc_ext;
                end
            end
        end
    end

    assign o_busy     = r_pc_vld;
    assign o_wifi_acc = r_wifi_acc;
    assign o_ble_acc  = r_ble_acc;

endmodule

// ===== src/dbc_checker.sv =====
module dbc_checker #(
    parameter int OUT_DATA_W = 40
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    // reset starts a clearing pass, so no transaction is taken right after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // every accepted transaction takes the block out of idle, so input ready drops after it
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready in the cycle after a transaction");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed under stall");

endmodule

bind distinct_id_bitmap_counter dbc_checker #(
    .OUT_DATA_W (OUT_DATA_W)
) u_dbc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
